FILE: hw/rtl/mlpq_pkg.sv
// Shared constants, codes and helper functions of the multilevel priority queue scheduler.
`timescale 1ns / 1ps

package mlpq_pkg;

    // Queue organisation
    localparam int NUM_LEVELS   = 5;
    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 8;

    // Fixed field widths of the channels
    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;

    // Derived internal widths
    localparam int LEVEL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_DEPTH);

    // Operation codes
    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DISP = 2'd1;
    localparam logic [OP_W-1:0] OP_PRE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef logic [LEVEL_W-1:0]      level_t;
    typedef logic [PTR_W-1:0]        ptr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [TASK_ID_BITS-1:0] tid_t;

    // Saturate a requested level to the lowest existing level
    function automatic level_t clamp_level(input logic [PRIO_W-1:0] req);
        if (int'(req) >= NUM_LEVELS)
        begin
            return LEVEL_W'(NUM_LEVELS - 1);
        end
        return LEVEL_W'(req);
    endfunction

    // Advance a ring pointer with wrap at the queue depth
    function automatic ptr_t next_pos(input ptr_t p);
        if (int'(p) == QUEUE_DEPTH - 1)
        begin
            return '0;
        end
        return p + ptr_t'(1);
    endfunction

    // Flat store address of one slot of one level
    function automatic addr_t slot_addr(input level_t lv, input ptr_t pos);
        return ADDR_W'(int'(lv) * QUEUE_DEPTH + int'(pos));
    endfunction

endpackage

FILE: hw/rtl/mlpq_cmd_if.sv
// Command channel: valid/ready handshake carrying one scheduler command.
`timescale 1ns / 1ps

interface mlpq_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [mlpq_pkg::OP_W-1:0]    op;
    logic [mlpq_pkg::ID_W-1:0]    task_id;
    logic [mlpq_pkg::PRIO_W-1:0]  priority_req;

    modport source (output valid, output op, output task_id, output priority_req,
                    input ready);
    modport sink   (input valid, input op, input task_id, input priority_req,
                    output ready);
endinterface

FILE: hw/rtl/mlpq_rsp_if.sv
// Response channel: valid/ready handshake carrying one scheduler result.
`timescale 1ns / 1ps

interface mlpq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [mlpq_pkg::STATUS_W-1:0]  status;
    logic [mlpq_pkg::ID_W-1:0]      task_id_out;
    logic [mlpq_pkg::PRIO_W-1:0]    priority_out;
    logic                           running_valid;

    modport source (output valid, output status, output task_id_out,
                    output priority_out, output running_valid, input ready);
    modport sink   (input valid, input status, input task_id_out,
                    input priority_out, input running_valid, output ready);
endinterface

FILE: hw/rtl/mlpq_store.sv
// Task id store of all level queues: one write port, one registered read port.
`timescale 1ns / 1ps

module mlpq_store (
    input  logic                  clk,
    input  logic                  wr_en,
    input  mlpq_pkg::addr_t       wr_addr,
    input  mlpq_pkg::tid_t        wr_data,
    input  logic                  rd_en,
    input  mlpq_pkg::addr_t       rd_addr,
    output mlpq_pkg::tid_t        rd_data
);

    mlpq_pkg::tid_t mem [mlpq_pkg::MEM_DEPTH];
    mlpq_pkg::tid_t rd_data_reg;

    // Write the appended task id
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the head entry read; hold it until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/multilevel_priority_fifo_preempt_core.sv
// Top level of the multilevel priority queue scheduler with preemption.
// A command is accepted and latched together with the task id store read of the head
//   entry, executed once the result register is free, and its result is registered at
//   the end of the execution cycle. A new command is accepted only after the previous
//   one has executed: the store is read on acceptance and written back on execution.
// Reset: all queues empty, no running task, no result pending; the store needs no clearing.
`timescale 1ns / 1ps

module multilevel_priority_fifo_preempt_core (
    input logic        clk,
    input logic        rst_n,
    mlpq_cmd_if.sink   cmd,
    mlpq_rsp_if.source rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Sequencer and latched command
    logic                          state_reg, state_next;
    logic [mlpq_pkg::OP_W-1:0]     op_reg;
    mlpq_pkg::tid_t                id_reg;
    mlpq_pkg::level_t              lv_reg;
    logic                          disp_hit_reg, disp_hit_next;
    mlpq_pkg::level_t              disp_lv_reg, disp_lv_next;

    // Queue pointers and running task
    mlpq_pkg::ptr_t   head_reg  [mlpq_pkg::NUM_LEVELS];
    mlpq_pkg::ptr_t   head_next [mlpq_pkg::NUM_LEVELS];
    mlpq_pkg::ptr_t   tail_reg  [mlpq_pkg::NUM_LEVELS];
    mlpq_pkg::ptr_t   tail_next [mlpq_pkg::NUM_LEVELS];
    mlpq_pkg::cnt_t   count_reg [mlpq_pkg::NUM_LEVELS];
    mlpq_pkg::cnt_t   count_next[mlpq_pkg::NUM_LEVELS];
    logic             run_present_reg, run_present_next;
    mlpq_pkg::tid_t   run_id_reg, run_id_next;
    mlpq_pkg::level_t run_lv_reg, run_lv_next;

    // Result register
    logic                            out_valid_reg, out_valid_next;
    logic [mlpq_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    mlpq_pkg::tid_t                  out_id_reg, out_id_next;
    mlpq_pkg::level_t                out_lv_reg, out_lv_next;
    logic                            out_run_reg, out_run_next;

    // Store access
    logic             accept;
    logic             exec_go;
    logic             out_free;
    logic             mem_wr_en;
    mlpq_pkg::addr_t  mem_wr_addr;
    mlpq_pkg::tid_t   mem_wr_data;
    mlpq_pkg::addr_t  mem_rd_addr;
    mlpq_pkg::tid_t   mem_rd_data;
    mlpq_pkg::level_t push_lv;
    mlpq_pkg::tid_t   push_id;
    mlpq_pkg::level_t cmd_lv;

    assign out_free = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept = cmd.valid && cmd.ready;
    assign exec_go = (state_reg == ST_EXEC) && out_free;
    assign cmd_lv = mlpq_pkg::clamp_level(cmd.priority_req);

    // Pick the highest-priority non-empty level for a dispatch
    always_comb
    begin
        disp_hit_next = 1'b0;
        disp_lv_next  = '0;
        for (int l = mlpq_pkg::NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                disp_hit_next = 1'b1;
                disp_lv_next  = mlpq_pkg::LEVEL_W'(l);
            end
        end
    end

    assign mem_rd_addr = mlpq_pkg::slot_addr(disp_lv_next, head_reg[disp_lv_next]);

    // Append target: the command's level for enqueue, the running task's for preempt
    assign push_lv = (op_reg == mlpq_pkg::OP_ENQ) ? lv_reg : run_lv_reg;
    assign push_id = (op_reg == mlpq_pkg::OP_ENQ) ? id_reg : run_id_reg;
    assign mem_wr_addr = mlpq_pkg::slot_addr(push_lv, tail_reg[push_lv]);
    assign mem_wr_data = push_id;

    mlpq_store u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Execute the latched command and update queues, running task and result
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        run_present_next = run_present_reg;
        run_id_next      = run_id_reg;
        run_lv_next      = run_lv_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_lv_next      = out_lv_reg;
        out_run_next     = out_run_reg;
        mem_wr_en        = 1'b0;

        if (accept)
        begin
            state_next = ST_EXEC;
        end

        if (exec_go)
        begin
            state_next      = ST_IDLE;
            out_valid_next  = 1'b1;
            out_status_next = mlpq_pkg::ST_OK;
            out_id_next     = '0;
            out_lv_next     = '0;
            case (op_reg)
                mlpq_pkg::OP_ENQ:
                begin
                    if (int'(count_reg[lv_reg]) >= mlpq_pkg::QUEUE_DEPTH)
                    begin
                        out_status_next = mlpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_wr_en          = 1'b1;
                        tail_next[lv_reg]  = mlpq_pkg::next_pos(tail_reg[lv_reg]);
                        count_next[lv_reg] = count_reg[lv_reg] + mlpq_pkg::cnt_t'(1);
                    end
                end
                mlpq_pkg::OP_DISP:
                begin
                    if (!disp_hit_reg)
                    begin
                        out_status_next = mlpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        out_id_next             = mem_rd_data;
                        out_lv_next             = disp_lv_reg;
                        head_next[disp_lv_reg]  = mlpq_pkg::next_pos(head_reg[disp_lv_reg]);
                        count_next[disp_lv_reg] = count_reg[disp_lv_reg]
                                                  - mlpq_pkg::cnt_t'(1);
                        run_present_next        = 1'b1;
                        run_id_next             = mem_rd_data;
                        run_lv_next             = disp_lv_reg;
                    end
                end
                mlpq_pkg::OP_PRE:
                begin
                    if (!run_present_reg || run_lv_reg <= lv_reg)
                    begin
                        out_status_next = mlpq_pkg::ST_REFUSED;
                    end
                    else
                    begin
                        out_id_next = run_id_reg;
                        out_lv_next = run_lv_reg;
                        if (int'(count_reg[run_lv_reg]) >= mlpq_pkg::QUEUE_DEPTH)
                        begin
                            out_status_next = mlpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_wr_en              = 1'b1;
                            tail_next[run_lv_reg]  = mlpq_pkg::next_pos(tail_reg[run_lv_reg]);
                            count_next[run_lv_reg] = count_reg[run_lv_reg]
                                                     + mlpq_pkg::cnt_t'(1);
                            run_id_next            = id_reg;
                            run_lv_next            = lv_reg;
                        end
                    end
                end
                default:
                begin
                    out_status_next = mlpq_pkg::ST_OK;
                end
            endcase
            out_run_next = run_present_next;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            run_present_reg <= 1'b0;
            run_id_reg      <= '0;
            run_lv_reg      <= '0;
            out_valid_reg   <= 1'b0;
            for (int l = 0; l < mlpq_pkg::NUM_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            run_present_reg <= run_present_next;
            run_id_reg      <= run_id_next;
            run_lv_reg      <= run_lv_next;
            out_valid_reg   <= out_valid_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
        end
    end

    // Latch the accepted command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= cmd.op;
            id_reg       <= mlpq_pkg::TASK_ID_BITS'(cmd.task_id);
            lv_reg       <= cmd_lv;
            disp_hit_reg <= disp_hit_next;
            disp_lv_reg  <= disp_lv_next;
        end
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_lv_reg     <= out_lv_next;
        out_run_reg    <= out_run_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.task_id_out   = mlpq_pkg::ID_W'(out_id_reg);
    assign rsp.priority_out  = mlpq_pkg::PRIO_W'(out_lv_reg);
    assign rsp.running_valid = out_run_reg;

    // An accepted transaction always moves the sequencer to execution
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not enter execution");

    // The store is written only while a command executes
    a_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> exec_go)
        else $error("store written outside execution");

    // A running task appears only through a dispatch
    a_run_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(run_present_reg) |-> ($past(op_reg) == mlpq_pkg::OP_DISP))
        else $error("running task set by a command other than dispatch");

    // An executed command loads a result
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> out_valid_reg)
        else $error("executed command produced no result");

    // No level queue holds more than its depth
    generate
        for (genvar g = 0; g < mlpq_pkg::NUM_LEVELS; g++)
        begin : g_cnt_chk
            a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
                int'(count_reg[g]) <= mlpq_pkg::QUEUE_DEPTH)
                else $error("queue count beyond depth");
        end
    endgenerate

endmodule

FILE: sim/tb_multilevel_priority_fifo_preempt_core.sv
// Self-checking testbench of the multilevel priority queue scheduler with preemption.
`timescale 1ns / 1ps

module tb_multilevel_priority_fifo_preempt_core;

    import mlpq_pkg::*;

    // Opcode that the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 830;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     task_id;
        logic [PRIO_W-1:0]   level;
        logic                running;
    } sched_result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic              typed;
        sched_result_t     res;
    } sched_row_t;

    localparam sched_result_t NO_RES = '0;

    // Directed opening: fixed results where they are obvious, the rest predicted
    localparam sched_row_t DIRECTED_ROWS [24] = '{
        // empty scheduler: nothing to dispatch, nothing to preempt, unused opcode
        '{OP_DISP,   8'h00, 3'd0, 1'b1, '{ST_EMPTY,   8'h00, 3'd0, 1'b0}},
        '{OP_PRE,    8'h7F, 3'd0, 1'b1, '{ST_REFUSED, 8'h00, 3'd0, 1'b0}},
        '{OP_UNUSED, 8'hFF, 3'd7, 1'b1, '{ST_OK,      8'h00, 3'd0, 1'b0}},
        // enqueue at the extremes, levels above the lowest saturate
        '{OP_ENQ,    8'hFF, 3'd0, 1'b1, '{ST_OK,      8'h00, 3'd0, 1'b0}},
        '{OP_ENQ,    8'h00, 3'd4, 1'b1, '{ST_OK,      8'h00, 3'd0, 1'b0}},
        '{OP_ENQ,    8'hA5, 3'd7, 1'b1, '{ST_OK,      8'h00, 3'd0, 1'b0}},
        '{OP_ENQ,    8'h5A, 3'd5, 1'b1, '{ST_OK,      8'h00, 3'd0, 1'b0}},
        '{OP_ENQ,    8'h3C, 3'd2, 1'b0, NO_RES},
        '{OP_DISP,   8'h00, 3'd0, 1'b1, '{ST_OK,      8'hFF, 3'd0, 1'b1}},
        // nothing outranks a level 0 task
        '{OP_PRE,    8'h11, 3'd0, 1'b1, '{ST_REFUSED, 8'h00, 3'd0, 1'b1}},
        // dispatch over a running task, equal level refused, chained preemption
        '{OP_DISP,   8'h00, 3'd0, 1'b0, NO_RES},
        '{OP_PRE,    8'h22, 3'd2, 1'b0, NO_RES},
        '{OP_PRE,    8'h80, 3'd1, 1'b0, NO_RES},
        '{OP_PRE,    8'h01, 3'd0, 1'b0, NO_RES},
        '{OP_DISP,   8'h00, 3'd0, 1'b0, NO_RES},
        '{OP_DISP,   8'h00, 3'd0, 1'b0, NO_RES},
        '{OP_DISP,   8'h00, 3'd0, 1'b0, NO_RES},
        '{OP_PRE,    8'h33, 3'd6, 1'b0, NO_RES},
        '{OP_PRE,    8'h44, 3'd3, 1'b0, NO_RES},
        '{OP_DISP,   8'h00, 3'd0, 1'b0, NO_RES},
        '{OP_DISP,   8'h00, 3'd0, 1'b0, NO_RES},
        '{OP_DISP,   8'h00, 3'd0, 1'b0, NO_RES},
        // queues drained while a task still runs
        '{OP_DISP,   8'h00, 3'd0, 1'b1, '{ST_EMPTY,   8'h00, 3'd0, 1'b1}},
        '{OP_UNUSED, 8'h00, 3'd0, 1'b1, '{ST_OK,      8'h00, 3'd0, 1'b1}}
    };

    logic clk;
    logic rst_n;

    mlpq_cmd_if cmd_bus ();
    mlpq_rsp_if rsp_bus ();

    multilevel_priority_fifo_preempt_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // Shadow of the scheduler state
    tid_t lvl_store [NUM_LEVELS][QUEUE_DEPTH];
    int   lvl_head  [NUM_LEVELS] = '{default: 0};
    int   lvl_tail  [NUM_LEVELS] = '{default: 0};
    int   lvl_count [NUM_LEVELS] = '{default: 0};
    bit   run_present = 1'b0;
    tid_t run_id = '0;
    int   run_level = 0;

    sched_result_t sched_replies_due [$];

    // Fixed result travelling with the command, used instead of the prediction
    logic          cmd_typed;
    sched_result_t cmd_typed_res;

    int err_count   = 0;
    int items_sent  = 0;
    int replies_got = 0;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    // Append a task at the tail of one level; fail when that level is full
    function automatic bit level_append(input int lv, input tid_t id);
        if (lvl_count[lv] >= QUEUE_DEPTH)
        begin
            return 1'b0;
        end
        lvl_store[lv][lvl_tail[lv]] = id;
        lvl_tail[lv] = (lvl_tail[lv] + 1) % QUEUE_DEPTH;
        lvl_count[lv]++;
        return 1'b1;
    endfunction

    // Advance the shadow state by one command and return the reply it causes
    function automatic sched_result_t schedule_step(input logic [OP_W-1:0] op,
                                                   input logic [ID_W-1:0] id_in,
                                                   input logic [PRIO_W-1:0] prio_in);
        sched_result_t r;
        tid_t          id;
        int            lv;
        bit            popped;
        r = '0;
        r.status = ST_OK;
        id = tid_t'(id_in);
        lv = (int'(prio_in) >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(prio_in);
        popped = 1'b0;
        if (op == OP_ENQ)
        begin
            if (!level_append(lv, id))
            begin
                r.status = ST_FULL;
            end
        end
        else if (op == OP_DISP)
        begin
            // pop the lowest-numbered non-empty level and run that task
            r.status = ST_EMPTY;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                if (!popped && lvl_count[l] != 0)
                begin
                    run_id = lvl_store[l][lvl_head[l]];
                    run_level = l;
                    run_present = 1'b1;
                    lvl_head[l] = (lvl_head[l] + 1) % QUEUE_DEPTH;
                    lvl_count[l]--;
                    r.task_id = ID_W'(run_id);
                    r.level = PRIO_W'(l);
                    r.status = ST_OK;
                    popped = 1'b1;
                end
            end
        end
        else if (op == OP_PRE)
        begin
            if (!run_present || run_level <= lv)
            begin
                r.status = ST_REFUSED;
            end
            else
            begin
                // requeue the running task; a full level leaves everything as it was
                r.task_id = ID_W'(run_id);
                r.level = PRIO_W'(run_level);
                if (!level_append(run_level, run_id))
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    run_id = id;
                    run_level = lv;
                end
            end
        end
        r.running = run_present;
        return r;
    endfunction

    // Predict on each accepted command, check each accepted reply
    always @(posedge clk)
    begin : bus_watch
        sched_result_t want;
        sched_result_t predicted;
        if (rst_n)
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                predicted = schedule_step(cmd_bus.op, cmd_bus.task_id, cmd_bus.priority_req);
                sched_replies_due.push_back(cmd_typed ? cmd_typed_res : predicted);
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                replies_got++;
                if (sched_replies_due.size() == 0)
                begin
                    note_error($sformatf("reply %0d unexpected: status=%0d id=%02h lvl=%0d run=%0b",
                                         replies_got, rsp_bus.status, rsp_bus.task_id_out,
                                         rsp_bus.priority_out, rsp_bus.running_valid));
                end
                else
                begin
                    want = sched_replies_due.pop_front();
                    if (rsp_bus.status !== want.status || rsp_bus.task_id_out !== want.task_id
                        || rsp_bus.priority_out !== want.level
                        || rsp_bus.running_valid !== want.running)
                    begin
                        note_error($sformatf({"reply %0d mismatch: expected status=%0d id=%02h ",
                                              "lvl=%0d run=%0b, got status=%0d id=%02h lvl=%0d ",
                                              "run=%0b"},
                                             replies_got, want.status, want.task_id, want.level,
                                             want.running, rsp_bus.status, rsp_bus.task_id_out,
                                             rsp_bus.priority_out, rsp_bus.running_valid));
                    end
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Hard stop on a hang
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Send one command, with random idle cycles ahead of it set by the current phase
    task automatic issue_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                 input logic [PRIO_W-1:0] prio, input logic typed = 1'b0,
                                 input sched_result_t typed_res = '0);
        int phase;
        phase = (items_sent / 50) % 4;
        idle_pct  = (phase == 1) ? 62 : (phase == 3) ? 13 : 0;
        stall_pct = (phase == 2) ? 62 : (phase == 3) ? 13 : 0;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.op           <= op;
        cmd_bus.task_id      <= id;
        cmd_bus.priority_req <= prio;
        cmd_typed            <= typed;
        cmd_typed_res        <= typed_res;
        @(posedge clk);
        while (cmd_bus.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        if (op != OP_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Hold the command channel until every pending reply has arrived
    task automatic wait_replies_drained();
        cmd_bus.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (sched_replies_due.size() != 0);
        @(posedge clk);
    endtask

    // Empty all levels, fill one to overflow, run a task from it, then try to preempt
    task automatic run_full_level_case();
        int queued;
        int lv;
        wait_replies_drained();
        queued = 0;
        foreach (lvl_count[l])
        begin
            queued += lvl_count[l];
        end
        lv = $urandom_range(1, NUM_LEVELS - 1);
        repeat (queued)
        begin
            issue_command(OP_DISP, ID_W'($urandom_range(0, 255)),
                          PRIO_W'($urandom_range(0, 7)));
        end
        repeat (QUEUE_DEPTH + 1)
        begin
            issue_command(OP_ENQ, ID_W'($urandom_range(0, 255)),
                          PRIO_W'((lv == NUM_LEVELS - 1) ?
                                  $urandom_range(NUM_LEVELS - 1, 7) : lv));
        end
        issue_command(OP_DISP, ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 7)));
        issue_command(OP_ENQ, ID_W'($urandom_range(0, 255)), PRIO_W'(lv));
        issue_command(OP_PRE, ID_W'($urandom_range(0, 255)),
                      PRIO_W'($urandom_range(0, lv - 1)));
        issue_command(OP_PRE, ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(lv, 7)));
    endtask

    initial
    begin : stimulus
        int pick;
        int r;
        int prio;
        logic [OP_W-1:0] op;
        cmd_bus.valid        = 1'b0;
        cmd_bus.op           = OP_ENQ;
        cmd_bus.task_id      = '0;
        cmd_bus.priority_req = '0;
        cmd_typed            = 1'b0;
        cmd_typed_res        = '0;
        rsp_bus.ready        = 1'b0;
        rst_n                = 1'b0;
        repeat (6)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        foreach (DIRECTED_ROWS[i])
        begin
            issue_command(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].id, DIRECTED_ROWS[i].prio,
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
        end
        run_full_level_case();

        // random bursts of mixed, filling, draining and overflow sequences
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                repeat ($urandom_range(8, 30))
                begin
                    r = $urandom_range(0, 99);
                    op = (r < 40) ? OP_ENQ : (r < 70) ? OP_DISP : (r < 95) ? OP_PRE : OP_UNUSED;
                    issue_command(op, ID_W'($urandom_range(0, 255)),
                                  PRIO_W'($urandom_range(0, 7)));
                end
            end
            else if (pick < 75)
            begin
                prio = $urandom_range(0, 7);
                repeat ($urandom_range(4, 20))
                begin
                    issue_command(OP_ENQ, ID_W'($urandom_range(0, 255)), PRIO_W'(prio));
                end
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(4, 40))
                begin
                    issue_command(OP_DISP, ID_W'($urandom_range(0, 255)),
                                  PRIO_W'($urandom_range(0, 7)));
                end
            end
            else
            begin
                run_full_level_case();
            end
        end

        // drain and settle
        wait_replies_drained();
        repeat (8)
        begin
            @(posedge clk);
        end
        if (sched_replies_due.size() != 0)
        begin
            note_error($sformatf("%0d replies never arrived", sched_replies_due.size()));
        end
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
